/* rtl/pfpm_pkg.sv */
package pfpm_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] FREQ_SCALE_RST   = 32'd200000000;
  localparam logic [DATA_W-1:0] PERIOD_SCALE_RST = 32'd10000000;
  localparam logic [DATA_W-1:0] ALL_ONES         = '1;

  // Register index, taken from paddr[2]
  localparam logic REG_FREQ_SCALE   = 1'b0;
  localparam logic REG_PERIOD_SCALE = 1'b1;

  // Input word
  typedef struct packed {
    logic command;
    logic pin_level;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [DATA_W-1:0] frequency_out;
    logic [DATA_W-1:0] period_out;
    logic              new_measurement;
  } out_word_t;

  // Job kinds handed from front to back
  typedef enum logic [1:0] {
    OP_TICK,
    OP_EDGE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] count;
  } job_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/pfpm_front.sv */
module pfpm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  pfpm_pkg::in_word_t in_word_i,
  output pfpm_pkg::job_t    job_o
);

  logic                        prev_pin_q, prev_pin_d;
  logic [pfpm_pkg::DATA_W-1:0] tick_count_q, tick_count_d;
  logic [pfpm_pkg::DATA_W-1:0] count_inc;
  logic                        rise;

  // Saturating count that includes this tick
  assign count_inc = (tick_count_q == pfpm_pkg::ALL_ONES) ? tick_count_q
                                                          : tick_count_q + 1'b1;
  assign rise      = in_word_i.pin_level & ~prev_pin_q;

  // Classify the word into a job for the back end
  always_comb begin
    prev_pin_d   = prev_pin_q;
    tick_count_d = tick_count_q;
    job_o.count  = count_inc;
    if (in_word_i.command) begin
      job_o.op = pfpm_pkg::OP_CLEAR;
    end else if (rise) begin
      job_o.op = pfpm_pkg::OP_EDGE;
    end else begin
      job_o.op = pfpm_pkg::OP_TICK;
    end
    if (accept_i && !in_word_i.command) begin
      prev_pin_d   = in_word_i.pin_level;
      tick_count_d = rise ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pin_q   <= 1'b0;
      tick_count_q <= '0;
    end else begin
      prev_pin_q   <= prev_pin_d;
      tick_count_q <= tick_count_d;
    end
  end

endmodule

/* rtl/pfpm_queue.sv */
module pfpm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  pfpm_pkg::job_t wr_job_i,
  input  logic           rd_i,
  output pfpm_pkg::job_t rd_job_o,
  output logic           full_o,
  output logic           empty_o
);

  pfpm_pkg::job_t                  mem_q [pfpm_pkg::QUEUE_DEPTH];
  logic [pfpm_pkg::QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [pfpm_pkg::QUEUE_AW:0]     count_q;
  logic                            do_wr, do_rd;

  assign full_o   = (count_q == (pfpm_pkg::QUEUE_AW+1)'(pfpm_pkg::QUEUE_DEPTH));
  assign empty_o  = (count_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_job_o = mem_q[rd_ptr_q];

  // Store incoming jobs
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/pfpm_div.sv */
module pfpm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfpm_pkg::div_req_t req_i,
  output pfpm_pkg::div_rsp_t rsp_o
);

  logic [pfpm_pkg::DATA_W-1:0]    rem_q, quo_q, den_q;
  logic [pfpm_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;
  logic [pfpm_pkg::DATA_W:0]      rem_sh, trial;
  logic [pfpm_pkg::DATA_W-1:0]    rem_next;
  logic                           bit_next;
  logic                           last_step;

  // One restoring step; a zero divisor yields all ones on its own
  assign rem_sh   = {rem_q, quo_q[pfpm_pkg::DATA_W-1]};
  assign trial    = rem_sh - {1'b0, den_q};
  assign bit_next = ~trial[pfpm_pkg::DATA_W];
  assign rem_next = bit_next ? trial[pfpm_pkg::DATA_W-1:0] : rem_sh[pfpm_pkg::DATA_W-1:0];

  assign last_step = busy_q && (cnt_q == pfpm_pkg::DIV_CNT_W'(pfpm_pkg::DIV_STEPS - 1));

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  // Datapath: load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[pfpm_pkg::DATA_W-2:0], bit_next};
    end else if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end
  end

endmodule

/* rtl/pfpm_back.sv */
module pfpm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pfpm_pkg::DATA_W-1:0] freq_scale_i,
  input  logic [pfpm_pkg::DATA_W-1:0] period_scale_i,
  input  logic                        q_empty_i,
  input  pfpm_pkg::job_t              q_job_i,
  output logic                        q_rd_o,
  output pfpm_pkg::div_req_t          div_req_o,
  input  pfpm_pkg::div_rsp_t          div_rsp_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output pfpm_pkg::out_word_t         out_word_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_FREQ,
    B_PER
  } state_e;

  state_e                      state_q;
  logic [pfpm_pkg::DATA_W-1:0] freq_q, per_q;
  pfpm_pkg::out_word_t         out_q;
  logic                        out_valid_q;
  logic                        take;
  logic                        out_set;

  // Take a job once the result slot is free or being emptied
  assign take    = (state_q == B_IDLE) && !q_empty_i && (!out_valid_q || pop_i);
  assign q_rd_o  = take;
  assign empty_o = !out_valid_q;
  assign out_word_o = out_q;

  // Fill the result slot on a tick or clear, or when the period is ready
  assign out_set = (take && (q_job_i.op != pfpm_pkg::OP_EDGE)) ||
                   ((state_q == B_PER) && div_rsp_i.done);

  // Frequency first, then period from the fresh frequency
  always_comb begin
    div_req_o.start = (take && (q_job_i.op == pfpm_pkg::OP_EDGE)) ||
                      ((state_q == B_FREQ) && div_rsp_i.done);
    div_req_o.num   = (state_q == B_FREQ) ? period_scale_i : freq_scale_i;
    div_req_o.den   = (state_q == B_FREQ) ? div_rsp_i.quo : q_job_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      freq_q      <= '0;
      per_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_set || (out_valid_q && !pop_i);
      case (state_q)
        B_IDLE: begin
          if (take) begin
            case (q_job_i.op)
              pfpm_pkg::OP_CLEAR: begin
                freq_q <= '0;
                per_q  <= '0;
                out_q  <= '0;
              end
              pfpm_pkg::OP_EDGE: begin
                state_q <= B_FREQ;
              end
              default: begin
                out_q <= '{frequency_out: freq_q, period_out: per_q,
                           new_measurement: 1'b0};
              end
            endcase
          end
        end
        B_FREQ: begin
          if (div_rsp_i.done) begin
            freq_q  <= div_rsp_i.quo;
            state_q <= B_PER;
          end
        end
        B_PER: begin
          if (div_rsp_i.done) begin
            per_q   <= div_rsp_i.quo;
            out_q   <= '{frequency_out: freq_q, period_out: div_rsp_i.quo,
                         new_measurement: 1'b1};
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

/* rtl/pulse_frequency_period_meter.sv */
// Path: a tick or clear word passes the job queue and the result register before it can be
// popped; a rising-edge word also waits for two 32-step divisions in the divider.
// Flow: the front end takes one word per cycle while its 4-entry job queue has room; the back
// end retires a tick or clear per cycle while results are popped, and no job while dividing.
// Reset: rst_ni is asynchronous, active low; it restores the scale registers to their
// defaults and clears the pin history, tick count, results and job queue.
module pulse_frequency_period_meter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pfpm_pkg::PADDR_W-1:0] paddr,
  input  logic [pfpm_pkg::DATA_W-1:0]  pwdata,
  output logic [pfpm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  pfpm_pkg::in_word_t           in_word_i,
  output logic                         empty,
  input  logic                         pop,
  output pfpm_pkg::out_word_t          out_word_o
);

  logic [pfpm_pkg::DATA_W-1:0] freq_scale_q, period_scale_q;
  logic                        cfg_wr, accept, q_rd, q_empty;
  pfpm_pkg::job_t              front_job, q_job;
  pfpm_pkg::div_req_t          div_req;
  pfpm_pkg::div_rsp_t          div_rsp;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == pfpm_pkg::REG_PERIOD_SCALE) ? period_scale_q : freq_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_scale_q   <= pfpm_pkg::FREQ_SCALE_RST;
      period_scale_q <= pfpm_pkg::PERIOD_SCALE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == pfpm_pkg::REG_FREQ_SCALE) begin
        freq_scale_q <= pwdata;
      end else begin
        period_scale_q <= pwdata;
      end
    end
  end

  assign accept = push && !full;

  pfpm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .job_o     (front_job)
  );

  pfpm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_job_i (front_job),
    .rd_i     (q_rd),
    .rd_job_o (q_job),
    .full_o   (full),
    .empty_o  (q_empty)
  );

  pfpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pfpm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .freq_scale_i   (freq_scale_q),
    .period_scale_i (period_scale_q),
    .q_empty_i      (q_empty),
    .q_job_i        (q_job),
    .q_rd_o         (q_rd),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_word_o     (out_word_o)
  );

  // Never start the divider while it iterates
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // A finished division leaves the divider free
  a_div_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> !div_rsp.busy && $past(div_rsp.busy))
    else $error("divider done without a running division");

  // An accepted word is waiting in the job queue on the next cycle
  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !q_empty)
    else $error("job queue lost an accepted word");

endmodule
